// ===== rtl/core/integer_to_ascii_formatter_assert.svh =====
// Assertion macros for the integer to ASCII formatter checker
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Checked while out of reset
`define ITOA_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define ITOA_CHK_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/itoa_pkg.sv =====
// Shared types, codes and character helpers of the integer to ASCII formatter
package itoa_pkg;

  localparam logic [2:0] MODE_SDEC = 3'd0;
  localparam logic [2:0] MODE_UDEC = 3'd1;
  localparam logic [2:0] MODE_HEXL = 3'd2;
  localparam logic [2:0] MODE_HEXU = 3'd3;
  localparam logic [2:0] MODE_PTR  = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  // x / 10 == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [63:0] RECIP10     = 64'h0000_0000_CCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam int ITOA_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] value;
  } itoa_in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic [4:0] char_index;
    logic       last_char;
  } itoa_out_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic [63:0] mag;
    logic        hex;
    logic        upper;
    logic        neg;
    logic        ptr;
  } itoa_job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    begin
      base = upper ? CH_UP_A : CH_LOW_A;
      if (d < 4'd10) digit_char = CH_ZERO + {4'd0, d};
      else           digit_char = base + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

// ===== rtl/core/itoa_front.sv =====
// Front end: takes requests and classifies them into digit jobs
module itoa_front
  import itoa_pkg::*;
(
  input  logic      start,
  input  logic      busy,
  input  itoa_in_t  in_req,
  output logic      push,
  output itoa_job_t job
);

  logic [31:0] low;
  logic        mode_ok;

  assign low = in_req.value[31:0];

  always_comb begin
    mode_ok   = 1'b1;
    job.mag   = {32'd0, low};
    job.hex   = 1'b0;
    job.upper = 1'b0;
    job.neg   = 1'b0;
    job.ptr   = 1'b0;
    case (in_req.mode)
      MODE_SDEC: begin
        if (low[31]) begin
          job.neg = 1'b1;
          job.mag = {32'd0, 32'd0 - low};
        end
      end
      MODE_UDEC: begin
      end
      MODE_HEXL: job.hex = 1'b1;
      MODE_HEXU: begin
        job.hex   = 1'b1;
        job.upper = 1'b1;
      end
      MODE_PTR: begin
        job.hex = 1'b1;
        job.ptr = 1'b1;
        job.mag = in_req.value;
      end
      default: mode_ok = 1'b0;   // unused modes print nothing
    endcase
  end

  assign push = start && !busy && mode_ok;

endmodule

// ===== rtl/core/itoa_queue.sv =====
// Small job queue between front and back
module itoa_queue
  import itoa_pkg::*;
#(
  parameter int DEPTH = ITOA_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  itoa_job_t push_data,
  input  logic      pop,
  output itoa_job_t pop_data,
  output logic      full,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  itoa_job_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/core/itoa_back.sv =====
// Back end: extracts digits least significant first, then emits characters
module itoa_back
  import itoa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  itoa_job_t q_data,
  output logic      q_pop,
  output logic      out_valid,
  output itoa_out_t out_res
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_REM  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  itoa_job_t   job_r, job_nxt;
  logic [63:0] x_r, x_nxt;
  logic [31:0] q_r, q_nxt;
  logic [3:0]  ndig_r, ndig_nxt;
  logic [3:0]  dptr_r, dptr_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [3:0]  digbuf_r [16];
  logic        dig_we;
  logic [3:0]  dig_wd;
  logic [63:0] prod;
  logic [31:0] rem;
  logic [4:0]  plen;
  logic        ov_nxt;
  itoa_out_t   ores_nxt;

  assign prod  = {32'd0, x_r[31:0]} * RECIP10;
  assign rem   = x_r[31:0] - ({q_r[28:0], 3'd0} + {q_r[30:0], 1'd0});
  assign plen  = job_r.neg ? 5'd1 : (job_r.ptr ? 5'd2 : 5'd0);
  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    x_nxt     = x_r;
    q_nxt     = q_r;
    ndig_nxt  = ndig_r;
    dptr_nxt  = dptr_r;
    idx_nxt   = idx_r;
    dig_we    = 1'b0;
    dig_wd    = x_r[3:0];
    ov_nxt    = 1'b0;
    ores_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          job_nxt   = q_data;
          x_nxt     = q_data.mag;
          ndig_nxt  = '0;
          idx_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (job_r.hex) begin
          dig_we   = 1'b1;
          x_nxt    = {4'd0, x_r[63:4]};
          dptr_nxt = ndig_r;
          ndig_nxt = ndig_r + 1'b1;
          if (x_r[63:4] == '0) state_nxt = ST_EMIT;
        end else begin
          q_nxt     = 32'(prod >> RECIP_SHIFT);
          state_nxt = ST_REM;
        end
      end
      ST_REM: begin
        dig_we   = 1'b1;
        dig_wd   = rem[3:0];
        x_nxt    = {32'd0, q_r};
        dptr_nxt = ndig_r;
        ndig_nxt = ndig_r + 1'b1;
        state_nxt = (q_r == '0) ? ST_EMIT : ST_DIV;
      end
      ST_EMIT: begin
        ov_nxt              = 1'b1;
        ores_nxt.char_index = idx_r;
        idx_nxt             = idx_r + 1'b1;
        if (idx_r < plen) begin
          // sign or "0x" prefix
          if (job_r.neg)     ores_nxt.char_code = CH_MINUS;
          else if (idx_r[0]) ores_nxt.char_code = CH_X;
          else               ores_nxt.char_code = CH_ZERO;
        end else begin
          ores_nxt.char_code = digit_char(digbuf_r[dptr_r], job_r.upper);
          dptr_nxt           = dptr_r - 1'b1;
          if (dptr_r == '0) begin
            ores_nxt.last_char = 1'b1;
            state_nxt          = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    x_r     <= x_nxt;
    q_r     <= q_nxt;
    ndig_r  <= ndig_nxt;
    dptr_r  <= dptr_nxt;
    idx_r   <= idx_nxt;
    out_res <= ores_nxt;
    if (dig_we) digbuf_r[ndig_r] <= dig_wd;
  end

endmodule

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter: front classifier, job queue, digit back end
// An idle back end takes a request from the queue and extracts its digits, one hex digit per
// ST_DIV step or one decimal digit per ST_DIV and ST_REM pair (1..16 hex, 1..10 decimal digits),
// then emits its characters from ST_EMIT. It takes a new request only after the last character
// of the previous one; the queue holds requests, busy only while it is full.
// Synchronous active-low reset empties the queue and idles the back end; output never stalls.
module integer_to_ascii_formatter
  import itoa_pkg::*;
#(
  parameter int QUEUE_DEPTH = ITOA_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  itoa_in_t  in_req,
  output logic      out_valid,
  output itoa_out_t out_res
);

  logic      push, q_pop, q_empty;
  itoa_job_t push_job, q_data;

  itoa_front u_front (
    .start  (start),
    .busy   (busy),
    .in_req (in_req),
    .push   (push),
    .job    (push_job)
  );

  itoa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (busy),
    .empty     (q_empty)
  );

  itoa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// ===== rtl/core/itoa_checker.sv =====
// Port-level checker for the integer to ASCII formatter, bound to the top level
`include "integer_to_ascii_formatter_assert.svh"

module itoa_checker
  import itoa_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_valid,
  input itoa_out_t out_res
);

  logic       mid_char;
  logic       end_char;
  logic [4:0] idx_inc;

  assign mid_char = out_valid && !out_res.last_char;
  assign end_char = out_valid && out_res.last_char;
  assign idx_inc  = out_res.char_index + 5'd1;

  `ITOA_CHK_ALL(a_reset_quiet, !rst_n |=> !out_valid, "output strobe after reset")
  `ITOA_CHK_ALL(a_reset_free, !rst_n |=> !busy, "busy after reset")
  `ITOA_CHK(a_contig, mid_char |=> out_valid && out_res.char_index == $past(idx_inc), "index gap")
  `ITOA_CHK(a_restart, end_char |=> !out_valid || out_res.char_index == 5'd0, "index not zero")
  `ITOA_CHK(a_index_range, out_valid |-> out_res.char_index <= 5'd17, "character index past 17")

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the integer to ASCII formatter: directed and random requests, checked per char
module tb;
  import itoa_pkg::*;

  localparam int HALF_PERIOD      = 4;
  localparam int RESET_CYCLES     = 9;
  localparam int DRAIN_CYCLES     = 100;
  localparam int STALL_LIMIT      = 2000;
  localparam int RANDOM_PER_PHASE = 85;

  localparam logic [7:0] ASCII_ZERO  = "0";
  localparam logic [7:0] ASCII_LOW_A = "a";
  localparam logic [7:0] ASCII_UP_A  = "A";
  localparam logic [7:0] ASCII_MINUS = "-";
  localparam logic [7:0] ASCII_X     = "x";

  class char_scoreboard;
    itoa_out_t expected_chars[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function logic [7:0] digit_glyph(logic [3:0] d, bit upper);
      if (d < 4'd10) return ASCII_ZERO + {4'd0, d};
      return (upper ? ASCII_UP_A : ASCII_LOW_A) + {4'd0, d} - 8'd10;
    endfunction

    // Builds the text of one request and queues its characters
    function void note_request(itoa_in_t req);
      logic [7:0]  text[$];
      logic [7:0]  digits[$];
      logic [31:0] low;
      logic [63:0] mag;
      logic [63:0] radix;
      bit          upper;
      itoa_out_t   ch;
      low   = req.value[31:0];
      mag   = {32'd0, low};
      radix = 64'd10;
      upper = 1'b0;
      case (req.mode)
        MODE_SDEC: begin
          if (low[31]) begin
            text.push_back(ASCII_MINUS);
            low = 32'd0 - low;
            mag = {32'd0, low};
          end
        end
        MODE_UDEC: ;
        MODE_HEXL: radix = 64'd16;
        MODE_HEXU: begin
          radix = 64'd16;
          upper = 1'b1;
        end
        MODE_PTR: begin
          text.push_back(ASCII_ZERO);
          text.push_back(ASCII_X);
          radix = 64'd16;
          mag   = req.value;
        end
        default: return;
      endcase
      do begin
        digits.push_front(digit_glyph(4'(mag % radix), upper));
        mag = mag / radix;
      end while (mag != 0);
      foreach (digits[i]) text.push_back(digits[i]);
      foreach (text[k]) begin
        ch.char_code  = text[k];
        ch.char_index = 5'(k);
        ch.last_char  = (k == text.size() - 1);
        expected_chars.push_back(ch);
      end
    endfunction

    function void check_char(itoa_out_t got);
      itoa_out_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t unexpected char: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (got.char_code !== want.char_code) begin
        $display("%0t char_code: expected %h, actual %h", $time, want.char_code, got.char_code);
        errors++;
      end
      if (got.char_index !== want.char_index) begin
        $display("%0t char_index: expected %0d, actual %0d", $time,
                 want.char_index, got.char_index);
        errors++;
      end
      if (got.last_char !== want.last_char) begin
        $display("%0t last_char: expected %b, actual %b", $time, want.last_char, got.last_char);
        errors++;
      end
    endfunction

    function int leftover();
      return expected_chars.size();
    endfunction
  endclass

  logic      clk   = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  itoa_in_t  in_req = '0;
  logic      out_valid;
  itoa_out_t out_res;

  char_scoreboard sb;

  integer_to_ascii_formatter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  initial forever #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_req);
      if (out_valid) sb.check_char(out_res);
    end
  end

  // Ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((start && !busy) || out_valid)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic itoa_in_t mk(logic [2:0] m, logic [63:0] v);
    itoa_in_t r;
    r.mode  = m;
    r.value = v;
    return r;
  endfunction

  function automatic itoa_in_t noise();
    return itoa_in_t'({3'($urandom_range(0, 7)), $urandom, $urandom});
  endfunction

  function automatic logic [2:0] pick_mode();
    if ($urandom_range(0, 19) < 18) return 3'($urandom_range(0, 4));
    return 3'($urandom_range(5, 7));
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] p;
    logic [63:0] junk;
    p    = 64'd1;
    junk = {$urandom, 32'd0};
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 20)) | ($urandom_range(0, 1) ? junk : 64'd0);
      1: return {$urandom, $urandom};
      2: begin
        // digit-count boundaries: powers of ten or sixteen, one off either way
        if ($urandom_range(0, 1)) repeat ($urandom_range(0, 9)) p = p * 64'd10;
        else p = 64'd1 << (4 * $urandom_range(0, 15));
        return p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      3: begin
        case ($urandom_range(0, 3))
          0: return junk;
          1: return junk | 64'hFFFF_FFFF;
          2: return junk | 64'h8000_0000;
          default: return junk | 64'h7FFF_FFFF;
        endcase
      end
      4: return junk | 64'($urandom);
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  task automatic send_request(itoa_in_t req, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start  <= 1'b0;
      in_req <= noise();
    end
    @(negedge clk);
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.leftover() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_request(mk(pick_mode(), pick_value()), idle_pct);
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(mk(MODE_SDEC, 64'd0), 17);
    send_request(mk(MODE_SDEC, 64'd1), 17);
    send_request(mk(MODE_SDEC, 64'h0000_0000_7FFF_FFFF), 17);
    send_request(mk(MODE_SDEC, 64'h0000_0000_8000_0000), 17);
    send_request(mk(MODE_SDEC, 64'h0000_0000_FFFF_FFFF), 17);
    send_request(mk(MODE_SDEC, 64'hFFFF_FFFF_0000_0009), 17);
    send_request(mk(MODE_SDEC, 64'h0000_0001_FFFF_FFF6), 17);
    send_request(mk(MODE_UDEC, 64'd0), 17);
    send_request(mk(MODE_UDEC, 64'h0000_0000_FFFF_FFFF), 17);
    send_request(mk(MODE_UDEC, 64'hFFFF_FFFF_3B9A_CA00), 17);
    send_request(mk(MODE_UDEC, 64'd9), 17);
    send_request(mk(MODE_UDEC, 64'd10), 17);
    send_request(mk(MODE_HEXL, 64'd0), 17);
    send_request(mk(MODE_HEXL, 64'hFFFF_FFFF_DEAD_BEEF), 17);
    send_request(mk(MODE_HEXL, 64'h1234_5678_0000_000F), 17);
    send_request(mk(MODE_HEXU, 64'd0), 17);
    send_request(mk(MODE_HEXU, 64'h0000_0000_FFFF_FFFF), 17);
    send_request(mk(MODE_HEXU, 64'h0F0F_0000_ABCD_EF01), 17);
    send_request(mk(MODE_PTR, 64'd0), 17);
    send_request(mk(MODE_PTR, 64'hFFFF_FFFF_FFFF_FFFF), 17);
    send_request(mk(MODE_PTR, 64'd1), 17);
    send_request(mk(MODE_PTR, 64'h8000_0000_0000_0000), 17);
    send_request(mk(MODE_PTR, 64'h0123_4567_89AB_CDEF), 17);
    send_request(mk(3'd5, {$urandom, $urandom}), 17);
    send_request(mk(3'd6, {$urandom, $urandom}), 17);
    send_request(mk(3'd7, 64'hFFFF_FFFF_FFFF_FFFF), 17);
    wait_drained();

    run_phase(17);
    wait_drained();
    run_phase(69);
    wait_drained();
    run_phase(0);
    wait_drained();

    if (sb.errors == 0 && sb.leftover() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
